// ===== hw/rtl/qsu_pkg.sv =====
package qsu_pkg;

  // Kinds of result item.
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_EOS    = 2'd2;
  localparam logic [1:0] KIND_BREAK  = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic [15:0] line_count;
    logic        last;
  } out_item_t;

endpackage

// ===== hw/rtl/quoted_string_unescaper.sv =====
// Quoted-string unescaper. Each accepted byte is held in an input register and decoded
// combinationally into up to three result items, which leave one per cycle through the
// output register while out_stall_i is low. A byte with zero or one result is released once
// its result, if any, is loaded, so the block sustains one byte per cycle while unstalled; a
// byte with more results (an unknown escape, a cut-short \x or octal escape, or an end-of-stream
// transfer that flushes a pending escape) holds the input until its final result is loaded, as
// the single output register sets the pace. quote_char may only be written while the block is
// idle; writes are always taken. Zero in quote_char selects whitespace-delimited tokens.
module quoted_string_unescaper #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  qsu_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qsu_pkg::out_item_t  out_data_o
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhBody    = 4'd1;
  localparam logic [3:0] PhEsc     = 4'd2;
  localparam logic [3:0] PhHex0    = 4'd3;
  localparam logic [3:0] PhHex1    = 4'd4;
  localparam logic [3:0] PhOct1    = 4'd5;
  localparam logic [3:0] PhOct2    = 4'd6;
  localparam logic [3:0] PhEscCr   = 4'd7;
  localparam logic [3:0] PhAfterCr = 4'd8;

  localparam logic [7:0] ChBsl = 8'h5C;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChX   = 8'h78;
  localparam logic [7:0] ChN   = 8'h6E;
  localparam logic [7:0] ChR   = 8'h72;
  localparam logic [7:0] ChSp  = 8'h20;

  localparam int WideBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef struct packed {
    logic               has;
    qsu_pkg::out_item_t res;
    logic [3:0]         ph;
    logic               fin;
  } body_t;

  function automatic logic [15:0] clamp_cnt(logic [COUNT_BITS-1:0] v);
    logic [WideBits-1:0] w;
    w = WideBits'(v);
    if (w > WideBits'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_inc(logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return c == ChSp || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic qsu_pkg::out_item_t mk_data(logic [7:0] b);
    qsu_pkg::out_item_t r;
    r = '0;
    r.out_byte = b;
    r.out_kind = qsu_pkg::KIND_DATA;
    return r;
  endfunction

  function automatic qsu_pkg::out_item_t mk_end(logic [1:0] kind, logic [15:0] cnt);
    qsu_pkg::out_item_t r;
    r = '0;
    r.out_kind   = kind;
    r.line_count = cnt;
    return r;
  endfunction

  logic [7:0]            quote_q;
  logic                  in_valid_q;
  qsu_pkg::in_item_t     in_q;
  logic                  out_valid_q;
  qsu_pkg::out_item_t    out_q;
  logic [1:0]            idx_q;
  logic [3:0]            phase_q, phase_d;
  logic [3:0]            hex_q, hex_d;
  logic [7:0]            oct_q, oct_d;
  logic [COUNT_BITS-1:0] lines_q, lines_d;

  qsu_pkg::out_item_t    res_a [3];
  qsu_pkg::out_item_t    res_cur;
  logic [1:0]            res_n;
  body_t                 bd;
  logic [7:0]            c;
  logic [7:0]            oct_acc;
  logic                  can_load, step, load, commit;

  assign c       = in_q.in_byte;
  assign oct_acc = {oct_q[4:0], 3'b000} + {5'b0, c[2:0]};

  // Handling of an ordinary byte inside a quoted string.
  always_comb begin
    bd.has = 1'b0;
    bd.res = '0;
    bd.ph  = PhBody;
    bd.fin = 1'b0;
    if (c == quote_q) begin
      bd.has = 1'b1;
      bd.res = mk_end(qsu_pkg::KIND_CLOSED, clamp_cnt(lines_q));
      bd.ph  = PhIdle;
      bd.fin = 1'b1;
    end else if (c == ChBsl) begin
      bd.ph = PhEsc;
    end else if (c == ChCr || c == ChLf) begin
      bd.has = 1'b1;
      bd.res = mk_end(qsu_pkg::KIND_BREAK, clamp_cnt(count_inc(lines_q)));
      bd.ph  = (c == ChCr) ? PhAfterCr : PhIdle;
      bd.fin = 1'b1;
    end else begin
      bd.has = 1'b1;
      bd.res = mk_data(c);
    end
  end

  always_comb begin
    res_a[0] = '0;
    res_a[1] = '0;
    res_a[2] = '0;
    res_n    = 2'd0;
    phase_d  = phase_q;
    hex_d    = hex_q;
    oct_d    = oct_q;
    lines_d  = lines_q;
    if (quote_q == 8'h00) begin
      if (in_q.in_end) begin
        res_a[0] = mk_end(qsu_pkg::KIND_EOS, 16'h0);
        res_n    = 2'd1;
        phase_d  = PhIdle;
        hex_d    = '0;
        oct_d    = '0;
        lines_d  = '0;
      end else if (phase_q == PhIdle || phase_q == PhAfterCr) begin
        if (is_ws(c)) begin
          phase_d = PhIdle;
        end else begin
          res_a[0] = mk_data(c);
          res_n    = 2'd1;
          phase_d  = PhBody;
        end
      end else if (is_ws(c)) begin
        res_a[0] = mk_end(qsu_pkg::KIND_CLOSED, 16'h0);
        res_n    = 2'd1;
        phase_d  = PhIdle;
        hex_d    = '0;
        oct_d    = '0;
        lines_d  = '0;
      end else begin
        res_a[0] = mk_data(c);
        res_n    = 2'd1;
        phase_d  = PhBody;
      end
    end else if (in_q.in_end) begin
      // A pending escape is flushed ahead of the end-of-stream item.
      unique case (phase_q) inside
        PhEsc: begin
          res_a[0] = mk_data(ChBsl);
          res_a[1] = mk_end(qsu_pkg::KIND_EOS, clamp_cnt(lines_q));
          res_n    = 2'd2;
        end
        PhHex0: begin
          res_a[0] = mk_data(ChBsl);
          res_a[1] = mk_data(ChX);
          res_a[2] = mk_end(qsu_pkg::KIND_EOS, clamp_cnt(lines_q));
          res_n    = 2'd3;
        end
        PhHex1: begin
          res_a[0] = mk_data({4'h0, hex_q});
          res_a[1] = mk_end(qsu_pkg::KIND_EOS, clamp_cnt(lines_q));
          res_n    = 2'd2;
        end
        PhOct1, PhOct2: begin
          res_a[0] = mk_data(oct_q);
          res_a[1] = mk_end(qsu_pkg::KIND_EOS, clamp_cnt(lines_q));
          res_n    = 2'd2;
        end
        default: begin
          res_a[0] = mk_end(qsu_pkg::KIND_EOS, clamp_cnt(lines_q));
          res_n    = 2'd1;
        end
      endcase
      phase_d = PhIdle;
      hex_d   = '0;
      oct_d   = '0;
      lines_d = '0;
    end else begin
      unique case (phase_q) inside
        PhBody: begin
          res_a[0] = bd.res;
          res_n    = {1'b0, bd.has};
          phase_d  = bd.ph;
          if (bd.fin) begin
            lines_d = '0;
          end
        end
        PhEsc: begin
          phase_d = PhBody;
          if (c == ChBsl || c == quote_q) begin
            res_a[0] = mk_data(c);
            res_n    = 2'd1;
          end else if (c == ChX) begin
            phase_d = PhHex0;
          end else if (is_oct(c)) begin
            oct_d   = {5'b0, c[2:0]};
            phase_d = PhOct1;
          end else if (c == ChN) begin
            res_a[0] = mk_data(ChLf);
            res_n    = 2'd1;
          end else if (c == ChR) begin
            res_a[0] = mk_data(ChCr);
            res_n    = 2'd1;
          end else if (c == ChCr) begin
            lines_d = count_inc(lines_q);
            phase_d = PhEscCr;
          end else if (c == ChLf) begin
            lines_d = count_inc(lines_q);
          end else begin
            res_a[0] = mk_data(ChBsl);
            res_a[1] = mk_data(c);
            res_n    = 2'd2;
          end
        end
        PhHex0: begin
          if (is_hex(c)) begin
            hex_d   = hex_val(c);
            phase_d = PhHex1;
          end else begin
            res_a[0] = mk_data(ChBsl);
            res_a[1] = mk_data(ChX);
            res_a[2] = bd.res;
            res_n    = bd.has ? 2'd3 : 2'd2;
            phase_d  = bd.ph;
            if (bd.fin) begin
              lines_d = '0;
            end
          end
        end
        PhHex1: begin
          hex_d = '0;
          if (is_hex(c)) begin
            res_a[0] = mk_data({hex_q, hex_val(c)});
            res_n    = 2'd1;
            phase_d  = PhBody;
          end else begin
            res_a[0] = mk_data({4'h0, hex_q});
            res_a[1] = bd.res;
            res_n    = bd.has ? 2'd2 : 2'd1;
            phase_d  = bd.ph;
            if (bd.fin) begin
              lines_d = '0;
            end
          end
        end
        PhOct1, PhOct2: begin
          if (is_oct(c)) begin
            if (phase_q == PhOct2) begin
              res_a[0] = mk_data(oct_acc);
              res_n    = 2'd1;
              oct_d    = '0;
              phase_d  = PhBody;
            end else begin
              oct_d   = oct_acc;
              phase_d = PhOct2;
            end
          end else begin
            res_a[0] = mk_data(oct_q);
            res_a[1] = bd.res;
            res_n    = bd.has ? 2'd2 : 2'd1;
            oct_d    = '0;
            phase_d  = bd.ph;
            if (bd.fin) begin
              lines_d = '0;
            end
          end
        end
        PhEscCr: begin
          if (c == ChLf) begin
            phase_d = PhBody;
          end else begin
            res_a[0] = bd.res;
            res_n    = {1'b0, bd.has};
            phase_d  = bd.ph;
            if (bd.fin) begin
              lines_d = '0;
            end
          end
        end
        PhAfterCr: begin
          // A LF right after an unmasked CR is swallowed; any other byte opens a string.
          phase_d = (c == ChLf) ? PhIdle : PhBody;
        end
        default: begin
          phase_d = PhBody;
        end
      endcase
    end
  end

  // The result that leaves next, marked when it is the item's final one.
  always_comb begin
    res_cur      = res_a[idx_q];
    res_cur.last = (idx_q == res_n - 2'd1);
  end

  assign can_load = !out_valid_q || !out_stall_i;
  assign step     = in_valid_q && (res_n == 2'd0 || can_load);
  assign load     = step && (res_n != 2'd0);
  assign commit   = step && (res_n == 2'd0 || idx_q == res_n - 2'd1);

  assign in_stall_o  = in_valid_q && !commit;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q     <= 8'd34;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      phase_q     <= PhIdle;
      hex_q       <= '0;
      oct_q       <= '0;
      lines_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        quote_q <= cfg_data_i;
      end
      if (!in_valid_q || commit) begin
        in_valid_q <= in_valid_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        idx_q   <= 2'd0;
        phase_q <= phase_d;
        hex_q   <= hex_d;
        oct_q   <= oct_d;
        lines_q <= lines_d;
      end else if (load) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!in_valid_q || commit) && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (load) begin
      out_q <= res_cur;
    end
  end

  // The sequencer only ever points inside the current item's result list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && res_n != 2'd0) |-> (idx_q < res_n))
    else $error("result index beyond the item's result count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> in_valid_q)
    else $error("result index advanced without a held input item");

  // Until its final result leaves, the item stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_q.last) |-> in_valid_q)
    else $error("non-final result transferred after its input was released");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.out_kind == qsu_pkg::KIND_DATA) |-> (out_q.line_count == 16'h0))
    else $error("data result carries a line count");

endmodule
